// ----- hdl/crowa_pkg.sv -----
// ----------------------------------------------------------------------------
// crowa_pkg
// Shared constants, codes and types of the count rate window averager.
// ----------------------------------------------------------------------------
`default_nettype none
package crowa_pkg;
    localparam int WINDOW_LEN = 60;
    localparam int HOLD_LIMIT = 3;
    localparam int COUNT_W    = 24;
    localparam int RATE_W     = 32;
    localparam int FRAC_W     = 8;
    localparam int IDX_W      = $clog2(WINDOW_LEN);
    localparam int FILL_W     = $clog2(WINDOW_LEN + 1);
    localparam int ADDR_W     = IDX_W + 1;
    localparam int MEM_DEPTH  = 2 ** ADDR_W;
    localparam int SUM_W      = COUNT_W + FILL_W;
    localparam int DVD_W      = SUM_W + FRAC_W;
    localparam int RAD_W      = RATE_W + FRAC_W;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int REM_W      = ROOT_W + 2;
    localparam int CNT_W      = $clog2(DVD_W + 1);
    localparam int HCNT_W     = 2;
    localparam int HBUF_N     = 3;
    localparam logic [RATE_W-1:0] RATE_FLOOR = RATE_W'(51);

    localparam logic [1:0] V_ACCEPT  = 2'd0;
    localparam logic [1:0] V_HIGH    = 2'd1;
    localparam logic [1:0] V_LOW     = 2'd2;
    localparam logic [1:0] V_RESTART = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQRT,
        S_CMP,
        S_RST,
        S_DIVSET,
        S_DIV,
        S_FIN,
        S_OUT
    } t_state;
endpackage
`default_nettype wire

// ----- hdl/crowa_ram.sv -----
// ----------------------------------------------------------------------------
// crowa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module crowa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- hdl/count_rate_outlier_window_average.sv -----
// ----------------------------------------------------------------------------
// count_rate_outlier_window_average
// Per-segment moving average of counts with three-sigma outlier holding.
// ----------------------------------------------------------------------------
// Sequence: per input beat, 20 sqrt steps, 1 compare, 1 setup, 38 divide steps,
//   1 finish and 1 output load; a restart adds 3 replay writes, and an empty
//   window skips the divide.
// Flow: ready only in idle, so a new beat is taken only after the last result is
//   loaded; a result beat still waiting holds the next item in the output load.
// Reset: synchronous, active low; clears windows, sums, counts and history.
// ----------------------------------------------------------------------------
`default_nettype none
module count_rate_outlier_window_average (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [crowa_pkg::COUNT_W-1:0]  i_sample_count,
    input  wire logic                           i_range_segment,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic      [crowa_pkg::RATE_W-1:0]   o_mean_rate,
    output logic                                o_window_empty,
    output logic      [1:0]                     o_sample_verdict
);
    import crowa_pkg::*;

    t_state r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [COUNT_W-1:0] r_c, n_c;
    logic               r_seg, n_seg;
    logic [RATE_W-1:0]  r_hist, n_hist;
    logic [RAD_W-1:0]   r_rad, n_rad;
    logic [REM_W-1:0]   r_rem, n_rem;
    logic [ROOT_W-1:0]  r_root, n_root;
    logic [1:0]         r_verdict, n_verdict;
    logic [HCNT_W-1:0]  r_hcnt, n_hcnt, r_lcnt, n_lcnt;
    logic [COUNT_W-1:0] r_hbuf [HBUF_N];
    logic [COUNT_W-1:0] n_hbuf [HBUF_N];
    logic [COUNT_W-1:0] r_lbuf [HBUF_N];
    logic [COUNT_W-1:0] n_lbuf [HBUF_N];
    logic               r_rsel, n_rsel;
    logic [SUM_W-1:0]   r_sum [2];
    logic [SUM_W-1:0]   n_sum [2];
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic               r_full, n_full;
    logic [IDX_W-1:0]   r_off [2];
    logic [IDX_W-1:0]   n_off [2];
    logic [MEM_DEPTH-1:0] r_vld, n_vld;
    logic [DVD_W-1:0]   r_dq, n_dq;
    logic [FILL_W-1:0]  r_drem, n_drem;
    logic [FILL_W-1:0]  r_n, n_n;
    logic [RATE_W-1:0]  r_res, n_res;
    logic               r_rempty, n_rempty;
    logic               r_ovld, n_ovld;
    logic [RATE_W-1:0]  r_omean, n_omean;
    logic               r_oempty, n_oempty;
    logic [1:0]         r_overd, n_overd;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
    logic [COUNT_W-1:0] mem_wdata, mem_rdata, old_val, rst_val;
    logic [REM_W+1:0]   sq_t, sq_trial;
    logic [ROOT_W+1:0]  s3;
    logic [RATE_W:0]    hi_lim;
    logic [RATE_W-1:0]  cq, q_lo;
    logic [IDX_W:0]     psum;
    logic [IDX_W-1:0]   phys;
    logic [FILL_W:0]    dv_t;
    logic               is_high, is_low;

    crowa_ram #(
        .WIDTH(COUNT_W),
        .DEPTH(MEM_DEPTH)
    ) u_win (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    assign mem_raddr = {r_seg, r_off[r_seg]};
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovld;
    assign o_mean_rate = r_omean;
    assign o_window_empty = r_oempty;
    assign o_sample_verdict = r_overd;

    always_comb begin
        sq_t     = {r_rem, r_rad[RAD_W-1 -: 2]};
        sq_trial = {2'b00, r_root, 2'b01};
        s3       = {2'b00, r_root} + {1'b0, r_root, 1'b0};
        hi_lim   = {1'b0, r_hist} + (RATE_W+1)'(s3);
        cq       = {r_c, {FRAC_W{1'b0}}};
        is_high  = ({1'b0, cq} > hi_lim);
        is_low   = (r_hist > RATE_W'(s3)) && (cq < (r_hist - RATE_W'(s3)));
        psum     = {1'b0, r_off[r_seg]} + {1'b0, IDX_W'(r_fill)};
        phys     = (psum >= (IDX_W+1)'(WINDOW_LEN)) ?
                   IDX_W'(psum - (IDX_W+1)'(WINDOW_LEN)) : IDX_W'(psum);
        old_val  = r_vld[mem_raddr] ? mem_rdata : '0;
        rst_val  = r_rsel ? r_lbuf[r_cnt[HCNT_W-1:0]] : r_hbuf[r_cnt[HCNT_W-1:0]];
        dv_t     = {r_drem, r_dq[DVD_W-1]};
        q_lo     = r_dq[RATE_W-1:0];
    end

    always_comb begin
        n_state = r_state;   n_cnt = r_cnt;     n_c = r_c;       n_seg = r_seg;
        n_hist = r_hist;     n_rad = r_rad;     n_rem = r_rem;   n_root = r_root;
        n_verdict = r_verdict; n_hcnt = r_hcnt; n_lcnt = r_lcnt;
        n_hbuf = r_hbuf;     n_lbuf = r_lbuf;   n_rsel = r_rsel;
        n_sum = r_sum;       n_fill = r_fill;   n_full = r_full; n_off = r_off;
        n_vld = r_vld;       n_dq = r_dq;       n_drem = r_drem; n_n = r_n;
        n_res = r_res;       n_rempty = r_rempty;
        n_ovld = r_ovld && !i_ready;
        n_omean = r_omean;   n_oempty = r_oempty; n_overd = r_overd;
        mem_we = 1'b0;
        mem_waddr = {r_seg, phys};
        mem_wdata = r_c;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_c = i_sample_count;
                    n_seg = i_range_segment;
                    n_rad = {r_hist, {FRAC_W{1'b0}}};
                    n_rem = '0;
                    n_root = '0;
                    n_cnt = '0;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (sq_t >= sq_trial) begin
                    n_rem = REM_W'(sq_t - sq_trial);
                    n_root = {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    n_rem = REM_W'(sq_t);
                    n_root = {r_root[ROOT_W-2:0], 1'b0};
                end
                n_rad = {r_rad[RAD_W-3:0], 2'b00};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_cnt = '0;
                n_state = S_DIVSET;
                if (is_high || is_low) begin
                    n_rsel = !is_high;
                    if (is_high) begin
                        n_lcnt = '0;
                        n_hbuf[r_hcnt] = r_c;
                        n_hcnt = r_hcnt + 1'b1;
                        n_verdict = V_HIGH;
                    end else begin
                        n_hcnt = '0;
                        n_lbuf[r_lcnt] = r_c;
                        n_lcnt = r_lcnt + 1'b1;
                        n_verdict = V_LOW;
                    end
                    if ((is_high && r_hcnt == HCNT_W'(HOLD_LIMIT - 1)) ||
                        (!is_high && r_lcnt == HCNT_W'(HOLD_LIMIT - 1))) begin
                        n_hcnt = '0;
                        n_lcnt = '0;
                        n_verdict = V_RESTART;
                        n_vld = '0;
                        n_sum[0] = '0;
                        n_sum[1] = '0;
                        n_off[0] = '0;
                        n_off[1] = '0;
                        n_fill = '0;
                        n_full = 1'b0;
                        n_hist = '0;
                        n_state = S_RST;
                    end
                end else begin
                    n_hcnt = '0;
                    n_lcnt = '0;
                    n_verdict = V_ACCEPT;
                    mem_we = 1'b1;
                    if (r_fill < FILL_W'(WINDOW_LEN)) begin
                        n_vld[{r_seg, phys}] = 1'b1;
                        n_sum[r_seg] = r_sum[r_seg] + SUM_W'(r_c);
                        n_fill = r_fill + 1'b1;
                    end else begin
                        mem_waddr = mem_raddr;
                        n_vld[mem_raddr] = 1'b1;
                        n_sum[r_seg] = r_sum[r_seg] - SUM_W'(old_val) + SUM_W'(r_c);
                        n_off[r_seg] = (r_off[r_seg] == IDX_W'(WINDOW_LEN - 1)) ?
                                       '0 : r_off[r_seg] + 1'b1;
                        n_full = 1'b1;
                    end
                end
            end
            S_RST: begin
                mem_we = 1'b1;
                mem_waddr = {r_seg, IDX_W'(r_cnt)};
                mem_wdata = rst_val;
                n_vld[{r_seg, IDX_W'(r_cnt)}] = 1'b1;
                n_sum[r_seg] = r_sum[r_seg] + SUM_W'(rst_val);
                n_fill = r_fill + 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(HOLD_LIMIT - 1)) begin
                    n_state = S_DIVSET;
                end
            end
            S_DIVSET: begin
                n_n = r_full ? FILL_W'(WINDOW_LEN) : r_fill;
                n_dq = {r_sum[r_seg], {FRAC_W{1'b0}}};
                n_drem = '0;
                n_cnt = '0;
                if (!r_full && r_fill == '0) begin
                    n_res = '0;
                    n_rempty = 1'b1;
                    n_hist = RATE_FLOOR;
                    n_state = S_OUT;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (dv_t >= {1'b0, r_n}) begin
                    n_drem = FILL_W'(dv_t - {1'b0, r_n});
                    n_dq = {r_dq[DVD_W-2:0], 1'b1};
                end else begin
                    n_drem = FILL_W'(dv_t);
                    n_dq = {r_dq[DVD_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (|r_dq[DVD_W-1:RATE_W]) begin
                    n_res = '1;
                end else if (q_lo < RATE_FLOOR) begin
                    n_res = RATE_FLOOR;
                end else begin
                    n_res = q_lo;
                end
                n_hist = n_res;
                n_rempty = 1'b0;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ovld || i_ready) begin
                    n_ovld = 1'b1;
                    n_omean = r_res;
                    n_oempty = r_rempty;
                    n_overd = r_verdict;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;     r_c <= n_c;       r_seg <= n_seg;
        r_rad <= n_rad;     r_rem <= n_rem;   r_root <= n_root;
        r_verdict <= n_verdict;
        r_hbuf <= n_hbuf;   r_lbuf <= n_lbuf; r_rsel <= n_rsel;
        r_dq <= n_dq;       r_drem <= n_drem; r_n <= n_n;
        r_res <= n_res;     r_rempty <= n_rempty;
        r_omean <= n_omean; r_oempty <= n_oempty; r_overd <= n_overd;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hist <= '0;
            r_hcnt <= '0;
            r_lcnt <= '0;
            r_sum[0] <= '0;
            r_sum[1] <= '0;
            r_off[0] <= '0;
            r_off[1] <= '0;
            r_fill <= '0;
            r_full <= 1'b0;
            r_vld <= '0;
            r_ovld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hist <= n_hist;
            r_hcnt <= n_hcnt;
            r_lcnt <= n_lcnt;
            r_sum <= n_sum;
            r_off <= n_off;
            r_fill <= n_fill;
            r_full <= n_full;
            r_vld <= n_vld;
            r_ovld <= n_ovld;
        end
    end

    a_full_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> (r_fill == FILL_W'(WINDOW_LEN)))
        else $error("window full without full fill count");
    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(WINDOW_LEN))
        else $error("fill count beyond window length");
    a_restart_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_sample_verdict == V_RESTART) |-> !o_window_empty)
        else $error("restart beat reports empty window");
    a_hold_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |->
        (r_hcnt < HCNT_W'(HOLD_LIMIT)) && (r_lcnt < HCNT_W'(HOLD_LIMIT)))
        else $error("hold count reached limit at rest");
endmodule
`default_nettype wire

// ----- verif/count_rate_outlier_window_average_chk.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// count_rate_outlier_window_average_chk
// Watches both channels of the count rate averager. Predicts each result
// from the accepted input beats and compares it field by field with the
// result beats that come out.
// ----------------------------------------------------------------------------
module count_rate_outlier_window_average_chk (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic                          o_ready,
    input  wire logic [crowa_pkg::COUNT_W-1:0] i_sample_count,
    input  wire logic                          i_range_segment,
    input  wire logic                          o_valid,
    input  wire logic                          i_ready,
    input  wire logic [crowa_pkg::RATE_W-1:0]  o_mean_rate,
    input  wire logic                          o_window_empty,
    input  wire logic [1:0]                    o_sample_verdict,
    output int                                 fail_count,
    output int                                 pending_count
);
    import crowa_pkg::*;

    typedef struct packed {
        logic [RATE_W-1:0] mean_rate;
        logic              window_empty;
        logic [1:0]        sample_verdict;
    } t_rate_result;

    t_rate_result         rate_q[$];
    logic [COUNT_W-1:0]   win[2][WINDOW_LEN];
    logic [31:0]          wsum[2];
    int                   fill;
    bit                   full;
    logic [RATE_W-1:0]    hist;
    int                   hcnt;
    int                   lcnt;
    logic [COUNT_W-1:0]   hbuf[HBUF_N];
    logic [COUNT_W-1:0]   lbuf[HBUF_N];

    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    task automatic clear_windows();
        for (int s = 0; s < 2; s++) begin
            for (int i = 0; i < WINDOW_LEN; i++) win[s][i] = '0;
            wsum[s] = 0;
        end
        fill = 0;
        full = 0;
        hist = '0;
    endtask

    task automatic push_count(int seg, logic [COUNT_W-1:0] c);
        if (fill >= WINDOW_LEN) begin
            full = 1;
            wsum[seg] = wsum[seg] - win[seg][0];
            for (int i = 1; i < WINDOW_LEN; i++) win[seg][i-1] = win[seg][i];
            win[seg][WINDOW_LEN-1] = c;
        end else begin
            win[seg][fill] = c;
            fill++;
        end
        wsum[seg] = wsum[seg] + c;
    endtask

    task automatic predict_rate(logic [COUNT_W-1:0] c, int seg);
        logic [63:0]  h;
        logic [63:0]  s3;
        logic [63:0]  cq;
        logic [63:0]  m;
        int           n;
        t_rate_result r;
        h  = 64'(hist);
        s3 = 3 * root_floor(h << FRAC_W);
        cq = 64'(c) << FRAC_W;
        if (cq > h + s3) begin
            lcnt = 0;
            hbuf[hcnt % HBUF_N] = c;
            hcnt++;
            r.sample_verdict = V_HIGH;
            if (hcnt >= HOLD_LIMIT) begin
                clear_windows();
                for (int i = 0; i < HOLD_LIMIT; i++) push_count(seg, hbuf[i]);
                hcnt = 0;
                r.sample_verdict = V_RESTART;
            end
        end else if (h > s3 && cq < h - s3) begin
            hcnt = 0;
            lbuf[lcnt % HBUF_N] = c;
            lcnt++;
            r.sample_verdict = V_LOW;
            if (lcnt >= HOLD_LIMIT) begin
                clear_windows();
                for (int i = 0; i < HOLD_LIMIT; i++) push_count(seg, lbuf[i]);
                lcnt = 0;
                r.sample_verdict = V_RESTART;
            end
        end else begin
            push_count(seg, c);
            hcnt = 0;
            lcnt = 0;
            r.sample_verdict = V_ACCEPT;
        end
        n = full ? WINDOW_LEN : fill;
        if (n == 0) begin
            hist = RATE_FLOOR;
            r.mean_rate = '0;
            r.window_empty = 1'b1;
        end else begin
            m = (64'(wsum[seg]) << FRAC_W) / n;
            if (m < 64'(RATE_FLOOR)) m = 64'(RATE_FLOOR);
            if (m > 64'hFFFF_FFFF) m = 64'hFFFF_FFFF;
            hist = m[RATE_W-1:0];
            r.mean_rate = m[RATE_W-1:0];
            r.window_empty = 1'b0;
        end
        rate_q.push_back(r);
    endtask

    task automatic report(string what, logic [63:0] want, logic [63:0] got);
        $display("mismatch %s: expected %0d got %0d", what, want, got);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        clear_windows();
        hcnt = 0;
        lcnt = 0;
        for (int i = 0; i < HBUF_N; i++) begin
            hbuf[i] = '0;
            lbuf[i] = '0;
        end
    end

    assign pending_count = rate_q.size();

    always @(posedge i_clk) begin
        t_rate_result want;
        if (!i_rst_n) begin
            clear_windows();
            hcnt = 0;
            lcnt = 0;
            rate_q.delete();
        end else begin
            if (i_valid && o_ready) predict_rate(i_sample_count, int'(i_range_segment));
            if (o_valid && i_ready) begin
                if (rate_q.size() == 0) begin
                    report("unexpected beat", 0, 1);
                end else begin
                    want = rate_q.pop_front();
                    if (o_mean_rate !== want.mean_rate)
                        report("mean_rate", want.mean_rate, o_mean_rate);
                    if (o_window_empty !== want.window_empty)
                        report("window_empty", want.window_empty, o_window_empty);
                    if (o_sample_verdict !== want.sample_verdict)
                        report("sample_verdict", want.sample_verdict, o_sample_verdict);
                end
            end
        end
    end
endmodule

// ----- verif/count_rate_outlier_window_average_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// count_rate_outlier_window_average_tb
// Drives count beats into the averager: directed extremes and outlier runs,
// then random runs around a level with bursts and noise, with random
// stalls on both sides. The checker judges every result beat.
// ----------------------------------------------------------------------------
module count_rate_outlier_window_average_tb;
    import crowa_pkg::*;

    localparam int NUM_ITEMS = 1500;
    localparam int MAX_CYCLES = 2000000;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [COUNT_W-1:0] i_sample_count = '0;
    logic               i_range_segment = 1'b0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [RATE_W-1:0]  o_mean_rate;
    logic               o_window_empty;
    logic [1:0]         o_sample_verdict;
    logic               took = 1'b0;
    bit                 quiet = 0;
    int                 fail_count;
    int                 pending_count;
    int                 sent = 0;
    int                 cycles = 0;

    always #5 i_clk = ~i_clk;

    count_rate_outlier_window_average DUT (.*);

    count_rate_outlier_window_average_chk u_chk (.*);

    always @(posedge i_clk) begin
        took <= i_valid && o_ready;
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) i_ready <= quiet || ($urandom_range(0, 99) >= 6);
    end

    task automatic send(logic [COUNT_W-1:0] c, logic seg);
        if (!quiet && $urandom_range(0, 99) < 6) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 80)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample_count <= c;
        i_range_segment <= seg;
        do @(negedge i_clk); while (!took);
        sent++;
    endtask

    function automatic int root_of(int v);
        int r;
        r = 0;
        while ((r + 1) * (r + 1) <= v) r++;
        return r;
    endfunction

    function automatic logic [COUNT_W-1:0] clamp(longint v);
        if (v < 0) return '0;
        if (v > longint'(COUNT_MAX)) return COUNT_MAX;
        return v[COUNT_W-1:0];
    endfunction

    task automatic wait_drain();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_count != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    initial begin
        int  base;
        int  sd;
        int  len;
        int  scene;
        logic seg;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes, restarts, segment switch
        send(0, 0);
        send(5, 0);
        send(COUNT_MAX, 1);
        send(COUNT_MAX, 1);
        send(0, 0);
        send(1000, 0);
        send(1000, 0);
        send(1000, 1);
        send(1000, 0);
        send(1010, 0);
        send(0, 0);
        send(0, 1);
        send(1000, 0);
        send(0, 0);
        send(0, 0);
        send(0, 0);
        send(50000, 1);
        send(50000, 1);
        send(COUNT_MAX, 1);
        send(COUNT_MAX, 0);
        send(1, 1);
        send(COUNT_MAX, 1);
        wait_drain();

        seg = 0;
        while (sent < NUM_ITEMS) begin
            quiet = (sent > 600 && sent < 900);
            case ($urandom_range(0, 3))
                0: base = $urandom_range(0, 20);
                1: base = $urandom_range(20, 3000);
                2: base = $urandom_range(3000, 1000000);
                default: base = $urandom_range(1000000, 16777215);
            endcase
            sd = root_of(base);
            if ($urandom_range(0, 9) == 0) seg = ~seg;
            scene = $urandom_range(0, 9);
            if (scene <= 6) begin
                len = $urandom_range(10, 70);
                for (int i = 0; i < len; i++)
                    send(clamp(longint'(base) + $urandom_range(0, 2 * sd) - sd), seg);
            end else if (scene == 7) begin
                for (int i = 0; i < 3; i++)
                    send(clamp(longint'(base) * 4 + 100 + $urandom_range(0, 50)), seg);
            end else if (scene == 8) begin
                for (int i = 0; i < $urandom_range(2, 3); i++)
                    send(clamp($urandom_range(0, base / 20)), seg);
            end else begin
                send(COUNT_W'($urandom_range(0, 16777215)), 1'($urandom_range(0, 1)));
            end
            if (sent > 1000 && sent < 1100) wait_drain();
        end

        wait_drain();
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
